FILE: hdl/salc_pkg.sv
// ============================================================================
// salc_pkg
// Shared types and constants of the set-associative LRU cache tag model.
// ============================================================================
package salc_pkg;

  localparam int unsigned DEF_MAX_SETS   = 256;
  localparam int unsigned DEF_MAX_WAYS   = 8;
  localparam int unsigned DEF_ADDR_WIDTH = 64;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture the input item
    logic clr_step;  // start a clearing pass step
    logic rd_set;    // read the set row
    logic update;    // resolve and write back the set, update counters
  } salc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic modify;
  } salc_stat_t;

endpackage

FILE: hdl/salc_ctrl.sv
// ============================================================================
// salc_ctrl
// Sequencer: clearing pass after reset, then read, update and present each
// access result.
// ============================================================================
module salc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            in_command,
  input  salc_pkg::salc_stat_t  stat,
  output salc_pkg::salc_cmd_t   cmd,
  output logic                  out_last
);
  import salc_pkg::*;

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_READ = 5'b00100,
    S_UPD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   second_r, second_nxt;

  wire in_xfer  = in_valid && in_ready;
  wire out_xfer = out_valid && out_ready;

  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    out_last   = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_xfer) begin
          cmd.load_in = 1'b1;
          second_nxt  = 1'b0;
          // An unknown command makes no access.
          if (in_command == CMD_LOAD || in_command == CMD_STORE ||
              in_command == CMD_MODIFY) state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_set = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        out_last  = !(stat.modify && !second_r);
        if (out_xfer) begin
          if (out_last) state_nxt = S_IDLE;
          else begin
            second_nxt = 1'b1;
            state_nxt  = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

FILE: hdl/salc_dp.sv
// ============================================================================
// salc_dp
// Datapath: set memory, address split, tag compare, LRU update, counters.
// ============================================================================
module salc_dp #(
  parameter int unsigned MAX_SETS   = salc_pkg::DEF_MAX_SETS,
  parameter int unsigned MAX_WAYS   = salc_pkg::DEF_MAX_WAYS,
  parameter int unsigned ADDR_WIDTH = salc_pkg::DEF_ADDR_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [1:0]                        in_command,
  input  logic [63:0]                       in_address,
  input  salc_pkg::salc_cmd_t               cmd,
  output salc_pkg::salc_stat_t              stat,
  output logic [1:0]                        out_outcome,
  output logic [31:0]                       out_hits_total,
  output logic [31:0]                       out_misses_total,
  output logic [31:0]                       out_evictions_total
);
  import salc_pkg::*;

  localparam int unsigned SET_W  = $clog2(MAX_SETS) > 0 ? $clog2(MAX_SETS) : 1;
  localparam int unsigned SCAP   = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned NSETS  = 1 << SCAP;
  localparam int unsigned WAY_W  = $clog2(MAX_WAYS) > 0 ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_WAYS + 1);
  localparam int unsigned ROW_W  = MAX_WAYS * (1 + ADDR_WIDTH + WAY_W);

  typedef struct packed {
    logic [MAX_WAYS-1:0]                 valid;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
    logic [MAX_WAYS-1:0][WAY_W-1:0]      rank;
  } row_t;

  logic [3:0] set_bits_r;
  logic [5:0] blk_bits_r;
  logic [3:0] ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= 4'd1;
      blk_bits_r <= 6'd1;
      ways_r     <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_BITS:   set_bits_r <= cfg_data[3:0];
        REG_BLOCK_BITS: blk_bits_r <= cfg_data;
        REG_WAYS:       ways_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Captured item, split into set and tag once per item.
  logic                  modify_r;
  logic [SET_W-1:0]      set_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic [CNT_W-1:0]      nways_r;

  logic [ADDR_WIDTH-1:0] addr;
  logic [6:0]            s_eff, shift_tot;
  logic [ADDR_WIDTH-1:0] sh1;
  logic [CNT_W-1:0]      nways_c;

  always_comb begin
    addr  = in_address[ADDR_WIDTH-1:0];
    s_eff = (7'(set_bits_r) > 7'(SCAP)) ? 7'(SCAP) : 7'(set_bits_r);
    shift_tot = 7'(blk_bits_r) + s_eff;
    sh1 = (7'(blk_bits_r) >= 7'(ADDR_WIDTH)) ? '0 : (addr >> blk_bits_r);
    if (ways_r == 4'd0) nways_c = CNT_W'(1);
    else if (32'(ways_r) > MAX_WAYS) nways_c = CNT_W'(MAX_WAYS);
    else nways_c = CNT_W'(ways_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      modify_r <= (in_command == CMD_MODIFY);
      set_r    <= SET_W'(sh1 & ((ADDR_WIDTH'(1) << s_eff) - ADDR_WIDTH'(1)));
      tag_r    <= (shift_tot >= 7'(ADDR_WIDTH)) ? '0 : (addr >> shift_tot);
      nways_r  <= nways_c;
    end
  end

  // Set memory, cleared by a pass after reset.
  logic [ROW_W-1:0] mem [NSETS];
  logic [ROW_W-1:0] rd_q;
  logic [SET_W:0]   clr_r;
  logic             mem_we;
  logic [SET_W-1:0] mem_wa;
  logic [ROW_W-1:0] mem_wd;
  row_t             init_row, row, new_row;

  always_comb begin
    init_row = '0;
    for (int w = 0; w < MAX_WAYS; w++) init_row.rank[w] = WAY_W'(w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_step && !stat.clr_done) clr_r <= clr_r + 1'b1;
  end
  assign stat.clr_done = (32'(clr_r) >= NSETS);
  assign stat.modify   = modify_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.rd_set) rd_q <= mem[set_r];
  end

  // Hit search and victim choice.
  logic [MAX_WAYS-1:0] hitv;
  logic                hit, found_inv;
  logic [WAY_W-1:0]    hit_w, vic, sel;
  logic [WAY_W-1:0]    r_sel;

  always_comb begin
    row = row_t'(rd_q);
    hit = 1'b0; hit_w = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      hitv[w] = (CNT_W'(w) < nways_r) && row.valid[w] && (row.tag[w] == tag_r);
      if (hitv[w]) begin hit = 1'b1; hit_w = WAY_W'(w); end
    end
    found_inv = 1'b0; vic = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (CNT_W'(w) < nways_r) begin
        if (!row.valid[w] && !found_inv) begin
          found_inv = 1'b1; vic = WAY_W'(w);
        end else if ((!row.valid[w]) == found_inv && row.rank[w] < row.rank[vic]) begin
          vic = WAY_W'(w);
        end
      end
    end
    sel   = hit ? hit_w : vic;
    r_sel = row.rank[sel];
    new_row = row;
    for (int w = 0; w < MAX_WAYS; w++)
      if (row.rank[w] > r_sel) new_row.rank[w] = row.rank[w] - 1'b1;
    new_row.rank[sel] = WAY_W'(MAX_WAYS - 1);
    if (!hit) begin
      new_row.valid[sel] = 1'b1;
      new_row.tag[sel]   = tag_r;
    end
  end

  always_comb begin
    if (!stat.clr_done) begin
      mem_we = cmd.clr_step;
      mem_wa = clr_r[SET_W-1:0];
      mem_wd = ROW_W'(init_row);
    end else begin
      mem_we = cmd.update;
      mem_wa = set_r;
      mem_wd = ROW_W'(new_row);
    end
  end

  logic [1:0]  outcome_r;
  logic [31:0] hits_r, miss_r, evict_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r  <= '0;
      miss_r  <= '0;
      evict_r <= '0;
    end else if (cmd.update) begin
      if (hit) hits_r <= hits_r + 32'd1;
      else begin
        miss_r <= miss_r + 32'd1;
        if (!found_inv) evict_r <= evict_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) outcome_r <= hit ? OUT_HIT : (found_inv ? OUT_MISS : OUT_EVICT);
  end

  assign out_outcome         = outcome_r;
  assign out_hits_total      = hits_r;
  assign out_misses_total    = miss_r;
  assign out_evictions_total = evict_r;

endmodule

FILE: hdl/set_assoc_lru_cache_sim.sv
// ============================================================================
// set_assoc_lru_cache_sim
// Set-associative cache tag store with true LRU and hit/miss/eviction counts.
// ============================================================================
// After reset the block runs a clearing pass over the set memory, one set per
// cycle over the largest power of two not above MAX_SETS, and takes no item
// until it finishes. Each load or store then runs through capture, a read of
// the set row from the set memory, compare and LRU write-back, and the result
// transfer. A modify makes two accesses and two results, the first with last
// low; the second access goes back to the read and needs no capture. A result
// is held until out_ready takes it. An unknown command gives no result.
module set_assoc_lru_cache_sim #(
  parameter int unsigned MAX_SETS   = salc_pkg::DEF_MAX_SETS,
  parameter int unsigned MAX_WAYS   = salc_pkg::DEF_MAX_WAYS,
  parameter int unsigned ADDR_WIDTH = salc_pkg::DEF_ADDR_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_command,
  input  logic [63:0]                     in_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_outcome,
  output logic                            out_last,
  output logic [31:0]                     out_hits_total,
  output logic [31:0]                     out_misses_total,
  output logic [31:0]                     out_evictions_total
);
  import salc_pkg::*;

  salc_cmd_t  cmd;
  salc_stat_t stat;

  salc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .in_command, .stat, .cmd, .out_last
  );

  salc_dp #(
    .MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .ADDR_WIDTH(ADDR_WIDTH)
  ) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_command, .in_address,
    .cmd, .stat, .out_outcome, .out_hits_total, .out_misses_total,
    .out_evictions_total
  );

endmodule
